[rtl/core/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 cipher engine: item kinds, result
// status codes, datapath operations and the control/status bundles.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int PERM_SIZE  = 256;
  localparam int BYTE_W     = 8;
  localparam int KEY_CNT_W  = 9;
  localparam int STAT_W     = 2;

  // item kind carried on in_tuser
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // result status carried on out_tuser
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_KEY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_KEY_FULL = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,   // latch the accepted word
    OP_KEY,    // store key byte
    OP_FILL,   // identity fill of the permutation
    OP_SRDN,   // schedule: read S[n] and key[k]
    OP_SACC,   // schedule: update acc, read S[acc]
    OP_SWRN,   // schedule: S[n] = S[acc]
    OP_SWRA,   // schedule: S[acc] = old S[n], advance
    OP_DRDI,   // data: advance i, read S[i]
    OP_DRDJ,   // data: advance j, read S[j]
    OP_DWRI,   // data: S[i] = S[j]
    OP_DWRJ,   // data: S[j] = old S[i]
    OP_DRDT,   // data: read S[S[i] + S[j]]
    OP_DOUT    // data: form the result byte
  } rc4_op_t;

  typedef struct packed {
    rc4_op_t op;
    logic    out_load;
  } rc4_cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic key_ready;
    logic n_last;
  } rc4_stat_t;

endpackage

[rtl/core/rc4_ctrl.sv]
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the RC4 engine: steps one word through key storage, key
// schedule or keystream generation, then hands the result to the output.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  rc4_pkg::rc4_stat_t  dp_stat,
  output rc4_pkg::rc4_cmd_t   cmd
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_KEY  = 14'b00000000000010,
    ST_FILL = 14'b00000000000100,
    ST_SRDN = 14'b00000000001000,
    ST_SACC = 14'b00000000010000,
    ST_SWRN = 14'b00000000100000,
    ST_SWRA = 14'b00000001000000,
    ST_DRDI = 14'b00000010000000,
    ST_DRDJ = 14'b00000100000000,
    ST_DWRI = 14'b00001000000000,
    ST_DWRJ = 14'b00010000000000,
    ST_DRDT = 14'b00100000000000,
    ST_DOUT = 14'b01000000000000,
    ST_RESP = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = rc4_pkg::OP_NOP;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = rc4_pkg::OP_LOAD;
          state_nxt = ST_KEY;
        end
      end
      ST_KEY: begin
        // the word latched in IDLE decides the path
        if (dp_stat.mode == rc4_pkg::MODE_KEY) begin
          cmd.op = rc4_pkg::OP_KEY;
          state_nxt = dp_stat.last ? ST_FILL : ST_RESP;
        end else if (dp_stat.key_ready) begin
          state_nxt = ST_DRDI;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_FILL: begin
        cmd.op = rc4_pkg::OP_FILL;
        if (dp_stat.n_last) state_nxt = ST_SRDN;
      end
      ST_SRDN: begin
        cmd.op = rc4_pkg::OP_SRDN;
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        cmd.op = rc4_pkg::OP_SACC;
        state_nxt = ST_SWRN;
      end
      ST_SWRN: begin
        cmd.op = rc4_pkg::OP_SWRN;
        state_nxt = ST_SWRA;
      end
      ST_SWRA: begin
        cmd.op = rc4_pkg::OP_SWRA;
        state_nxt = dp_stat.n_last ? ST_RESP : ST_SRDN;
      end
      ST_DRDI: begin
        cmd.op = rc4_pkg::OP_DRDI;
        state_nxt = ST_DRDJ;
      end
      ST_DRDJ: begin
        cmd.op = rc4_pkg::OP_DRDJ;
        state_nxt = ST_DWRI;
      end
      ST_DWRI: begin
        cmd.op = rc4_pkg::OP_DWRI;
        state_nxt = ST_DWRJ;
      end
      ST_DWRJ: begin
        cmd.op = rc4_pkg::OP_DWRJ;
        state_nxt = ST_DRDT;
      end
      ST_DRDT: begin
        cmd.op = rc4_pkg::OP_DRDT;
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        cmd.op = rc4_pkg::OP_DOUT;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/rc4_dp.sv]
// ----------------------------------------------------------------------------
// rc4_dp
// RC4 datapath: key store, single-port permutation memory, indices, schedule
// counters and the result/status registers.
// ----------------------------------------------------------------------------
module rc4_dp #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rc4_pkg::rc4_cmd_t              cmd,
  input  logic                           in_mode,
  input  logic [rc4_pkg::BYTE_W-1:0]     in_value,
  input  logic                           in_last,
  output rc4_pkg::rc4_stat_t             dp_stat,
  output logic [rc4_pkg::BYTE_W-1:0]     res_byte,
  output logic [rc4_pkg::STAT_W-1:0]     res_stat
);

  localparam logic [rc4_pkg::KEY_CNT_W-1:0] KEY_MAX =
    rc4_pkg::KEY_CNT_W'(MAX_KEY_BYTES);

  logic [rc4_pkg::BYTE_W-1:0] perm_mem [rc4_pkg::PERM_SIZE];
  logic [rc4_pkg::BYTE_W-1:0] key_mem  [rc4_pkg::PERM_SIZE];

  // latched word
  logic                       mode_r, last_r;
  logic [rc4_pkg::BYTE_W-1:0] val_r;

  logic [rc4_pkg::KEY_CNT_W-1:0] key_count_r, key_count_nxt;
  logic                          key_ready_r, key_ready_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    i_r, i_nxt, j_r, j_nxt;

  logic [rc4_pkg::BYTE_W-1:0]    n_r, acc_r, acc_nxt;
  logic [rc4_pkg::KEY_CNT_W-1:0] k_r, k_inc;

  logic [rc4_pkg::BYTE_W-1:0] prd_r, krd_r, sn_r, si_r, sj_r;
  logic [rc4_pkg::BYTE_W-1:0] res_r;
  logic [rc4_pkg::STAT_W-1:0] stat_r;

  logic                       p_we, p_re;
  logic [rc4_pkg::BYTE_W-1:0] p_addr, p_wdata;

  assign acc_nxt = acc_r + prd_r + krd_r;
  assign i_nxt   = i_r + 8'd1;
  assign j_nxt   = j_r + prd_r;
  assign k_inc   = k_r + 9'd1;

  // permutation port select
  always_comb begin
    p_we    = 1'b0;
    p_re    = 1'b0;
    p_addr  = n_r;
    p_wdata = prd_r;
    unique case (cmd.op)
      rc4_pkg::OP_FILL: begin p_we = 1'b1; p_addr = n_r;  p_wdata = n_r; end
      rc4_pkg::OP_SRDN: begin p_re = 1'b1; p_addr = n_r; end
      rc4_pkg::OP_SACC: begin p_re = 1'b1; p_addr = acc_nxt; end
      rc4_pkg::OP_SWRN: begin p_we = 1'b1; p_addr = n_r;  p_wdata = prd_r; end
      rc4_pkg::OP_SWRA: begin p_we = 1'b1; p_addr = acc_r; p_wdata = sn_r; end
      rc4_pkg::OP_DRDI: begin p_re = 1'b1; p_addr = i_nxt; end
      rc4_pkg::OP_DRDJ: begin p_re = 1'b1; p_addr = j_nxt; end
      rc4_pkg::OP_DWRI: begin p_we = 1'b1; p_addr = i_r;  p_wdata = prd_r; end
      rc4_pkg::OP_DWRJ: begin p_we = 1'b1; p_addr = j_r;  p_wdata = si_r; end
      rc4_pkg::OP_DRDT: begin p_re = 1'b1; p_addr = si_r + sj_r; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      perm_mem[p_addr] <= p_wdata;
    end else if (p_re) begin
      prd_r <= perm_mem[p_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rc4_pkg::OP_KEY && key_count_r < KEY_MAX) begin
      key_mem[key_count_r[rc4_pkg::BYTE_W-1:0]] <= val_r;
    end
    if (cmd.op == rc4_pkg::OP_SRDN) begin
      krd_r <= key_mem[k_r[rc4_pkg::BYTE_W-1:0]];
    end
  end

  // control state next values
  always_comb begin
    key_count_nxt = key_count_r;
    key_ready_nxt = key_ready_r;
    unique case (cmd.op)
      rc4_pkg::OP_KEY: begin
        key_ready_nxt = 1'b0;
        if (key_count_r < KEY_MAX) key_count_nxt = key_count_r + 9'd1;
      end
      rc4_pkg::OP_SWRA: begin
        if (n_r == 8'hff) begin
          key_count_nxt = '0;
          key_ready_nxt = 1'b1;
        end
      end
      rc4_pkg::OP_DOUT: begin
        if (last_r) key_ready_nxt = 1'b0;
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      key_ready_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      key_count_r <= key_count_nxt;
      key_ready_r <= key_ready_nxt;
      if (cmd.op == rc4_pkg::OP_SWRA && n_r == 8'hff) begin
        i_r <= '0;
        j_r <= '0;
      end
      if (cmd.op == rc4_pkg::OP_DRDI) i_r <= i_nxt;
      if (cmd.op == rc4_pkg::OP_DRDJ) j_r <= j_nxt;
    end
  end

  // payload and schedule working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rc4_pkg::OP_LOAD: begin
        mode_r <= in_mode;
        val_r  <= in_value;
        last_r <= in_last;
        res_r  <= '0;
        stat_r <= (in_mode == rc4_pkg::MODE_DATA && !key_ready_r) ?
                  rc4_pkg::STAT_NO_KEY : rc4_pkg::STAT_OK;
      end
      rc4_pkg::OP_KEY: begin
        n_r   <= '0;
        k_r   <= '0;
        acc_r <= '0;
        if (key_count_r >= KEY_MAX) stat_r <= rc4_pkg::STAT_KEY_FULL;
      end
      rc4_pkg::OP_FILL: n_r <= n_r + 8'd1;
      rc4_pkg::OP_SACC: begin
        acc_r <= acc_nxt;
        sn_r  <= prd_r;
      end
      rc4_pkg::OP_SWRA: begin
        n_r <= n_r + 8'd1;
        // wrap the key index at the key length
        k_r <= (k_inc == key_count_r) ? '0 : k_inc;
      end
      rc4_pkg::OP_DRDJ: si_r <= prd_r;
      rc4_pkg::OP_DWRI: sj_r <= prd_r;
      rc4_pkg::OP_DOUT: res_r <= val_r ^ prd_r;
      default: begin end
    endcase
  end

  assign dp_stat.mode      = mode_r;
  assign dp_stat.last      = last_r;
  assign dp_stat.key_ready = key_ready_r;
  assign dp_stat.n_last    = (n_r == 8'hff);

  assign res_byte = res_r;
  assign res_stat = stat_r;

endmodule

[rtl/core/rc4_stream_cipher_top.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 cipher engine with stream input and output channels.
// ----------------------------------------------------------------------------
// Input words: in_tuser = 0 carries a key byte, 1 a data byte, in in_tdata.
// in_tlast on a key byte starts the key schedule; on a data byte it ends the
// session, after which a new key must be loaded. Every input word produces
// exactly one output word: out_tdata is the data byte XOR keystream (zero for
// key bytes and errors), out_tuser the status (ok, data without key, key byte
// beyond the store).
// One word is processed at a time; in_tready is high only while idle.
// A key byte or a rejected word goes from accept straight to the response; a
// data byte reads S[i] and S[j], swaps them, reads the keystream and forms the
// result; the final key byte first runs the identity fill and then 256 swap
// passes. The permutation memory is single-port, so its accesses take turns.
// The next word is accepted in the cycle after the result is handed to the
// output register, even while that result is still waiting.
// When out_tready is low the finished result holds in the output register and
// the next word parks before its hand-off. Reset clears the key and session
// state; the permutation memory holds no meaning until a key is scheduled.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top #(
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] value
  input  logic       in_tuser,   // [0] mode
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] result_byte
  output logic [1:0] out_tuser   // [1:0] status
);

  rc4_pkg::rc4_cmd_t  cmd;
  rc4_pkg::rc4_stat_t dp_stat;

  logic [rc4_pkg::BYTE_W-1:0] res_byte;
  logic [rc4_pkg::STAT_W-1:0] res_stat;
  logic                       out_free;

  logic                       out_valid_r;
  logic [rc4_pkg::BYTE_W-1:0] out_data_r;
  logic [rc4_pkg::STAT_W-1:0] out_user_r;

  assign out_free = !out_valid_r || out_tready;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_mode  (in_tuser),
    .in_value (in_tdata),
    .in_last  (in_tlast),
    .dp_stat  (dp_stat),
    .res_byte (res_byte),
    .res_stat (res_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_byte;
      out_user_r <= res_stat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/core/rc4_chk.sv]
// ----------------------------------------------------------------------------
// rc4_chk
// Port-level checks for the RC4 engine, bound to the top level.
// ----------------------------------------------------------------------------
module rc4_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == rc4_pkg::STAT_OK || out_tuser == rc4_pkg::STAT_NO_KEY ||
                    out_tuser == rc4_pkg::STAT_KEY_FULL))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rc4_pkg::STAT_OK |-> out_tdata == 8'h00)
    else $error("error word carries nonzero data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind rc4_stream_cipher_top rc4_chk u_rc4_chk (.*);

[dv/tb_rc4_stream_cipher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_stream_cipher_top
// Self-checking bench for the RC4 stream engine. Directed words cover data
// before any key, the shortest key, extreme bytes, session close, and a key
// reload mid-session. Random sessions follow: keys of random length (one of
// them longer than the key store), data runs, and stray or broken words.
// Each result is compared with the next prediction of the scoreboard.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher_top;

  localparam int KEY_STORE_BYTES = 256;
  localparam int RANDOM_WORDS    = 600;

  typedef struct {
    logic [7:0]                 text;
    logic [rc4_pkg::STAT_W-1:0] status;
  } cipher_word_t;

  class rc4_scoreboard;
    logic [7:0]   perm_state [rc4_pkg::PERM_SIZE];
    logic [7:0]   key_bytes  [rc4_pkg::PERM_SIZE];
    logic [8:0]   key_len;
    logic [7:0]   pos_i;
    logic [7:0]   pos_j;
    bit           session_open;
    int           store_limit;
    int           words_in;
    int           errors;
    cipher_word_t words_due [$];

    function new(int limit);
      store_limit  = limit;
      key_len      = '0;
      pos_i        = '0;
      pos_j        = '0;
      session_open = 1'b0;
      words_in     = 0;
      errors       = 0;
      foreach (perm_state[n]) begin
        perm_state[n] = '0;
        key_bytes[n]  = '0;
      end
    endfunction

    // Advance the cipher state for one accepted word and queue its result.
    function void note_word(logic mode, logic [7:0] value, logic last);
      cipher_word_t due;
      logic [7:0]   acc;
      logic [7:0]   kb;
      logic [7:0]   tmp;
      due.text   = '0;
      due.status = rc4_pkg::STAT_OK;
      words_in++;
      if (mode == rc4_pkg::MODE_KEY) begin
        session_open = 1'b0;
        if (int'(key_len) < store_limit && int'(key_len) < rc4_pkg::PERM_SIZE) begin
          key_bytes[key_len[7:0]] = value;
          key_len++;
        end else begin
          due.status = rc4_pkg::STAT_KEY_FULL;
        end
        if (last && key_len != 0) begin
          acc = '0;
          for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) perm_state[n] = 8'(n);
          for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
            kb  = key_bytes[8'(n % int'(key_len))];
            acc = acc + perm_state[n] + kb;
            tmp = perm_state[n];
            perm_state[n]   = perm_state[acc];
            perm_state[acc] = tmp;
          end
          pos_i        = '0;
          pos_j        = '0;
          key_len      = '0;
          session_open = 1'b1;
        end
      end else if (!session_open) begin
        due.status = rc4_pkg::STAT_NO_KEY;
      end else begin
        pos_i = pos_i + 8'd1;
        pos_j = pos_j + perm_state[pos_i];
        tmp = perm_state[pos_i];
        perm_state[pos_i] = perm_state[pos_j];
        perm_state[pos_j] = tmp;
        tmp = perm_state[pos_i] + perm_state[pos_j];
        due.text = value ^ perm_state[tmp];
        if (last) session_open = 1'b0;
      end
      words_due.push_back(due);
    endfunction

    function void check_word(logic [7:0] text, logic [rc4_pkg::STAT_W-1:0] status);
      cipher_word_t due;
      if (words_due.size() == 0) begin
        $display("%0t: unexpected word text %02h status %0d", $time, text, status);
        errors++;
        return;
      end
      due = words_due.pop_front();
      if (text !== due.text) begin
        $display("%0t: text expected %02h got %02h", $time, due.text, text);
        errors++;
      end
      if (status !== due.status) begin
        $display("%0t: status expected %0d got %0d", $time, due.status, status);
        errors++;
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [7:0] value
  logic       in_tuser   = 1'b0; // [0] mode
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] result_byte
  logic [1:0] out_tuser;         // [1:0] status
  bit         quiet_stretch = 1'b0;

  rc4_scoreboard sb = new(KEY_STORE_BYTES);

  rc4_stream_cipher_top #(
    .MAX_KEY_BYTES(KEY_STORE_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word, holding it until accepted; valid stays high on return.
  task automatic send_word(logic mode, logic [7:0] value, logic last);
    while (!quiet_stretch && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_word(mode, value, last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
      out_tready <= quiet_stretch || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    int key_run;
    int data_run;
    int long_key_at;
    int sess;
    bit close_run;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data before any key, with last set
    send_word(rc4_pkg::MODE_DATA, 8'hFF, 1'b1);
    // shortest key, a single zero byte
    send_word(rc4_pkg::MODE_KEY,  8'h00, 1'b1);
    send_word(rc4_pkg::MODE_DATA, 8'h00, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'hFF, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'hA5, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'h5A, 1'b1);
    // session closed: no key any more
    send_word(rc4_pkg::MODE_DATA, 8'h3C, 1'b0);
    send_word(rc4_pkg::MODE_KEY,  8'h4B, 1'b0);
    send_word(rc4_pkg::MODE_KEY,  8'h65, 1'b0);
    send_word(rc4_pkg::MODE_KEY,  8'h79, 1'b1);
    send_word(rc4_pkg::MODE_DATA, 8'h50, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'h6C, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'h61, 1'b0);
    // key byte mid-session drops the session
    send_word(rc4_pkg::MODE_KEY,  8'hFF, 1'b0);
    send_word(rc4_pkg::MODE_DATA, 8'h11, 1'b0);
    send_word(rc4_pkg::MODE_KEY,  8'h01, 1'b1);
    send_word(rc4_pkg::MODE_DATA, 8'h00, 1'b1);
    send_word(rc4_pkg::MODE_DATA, 8'hFF, 1'b0);

    long_key_at = $urandom_range(1, 4);
    sess = 0;
    while (sb.words_in < RANDOM_WORDS + 18) begin
      quiet_stretch <= (sess >= 3 && sess < 6);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_word(rc4_pkg::MODE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      // one key overruns the store; the last two bytes land past the end
      key_run = (sess == long_key_at) ? KEY_STORE_BYTES + 2 : $urandom_range(1, 16);
      for (int k = 0; k < key_run; k++) begin
        if ($urandom_range(19) == 0)
          send_word(rc4_pkg::MODE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        send_word(rc4_pkg::MODE_KEY, 8'($urandom_range(255)), k == key_run - 1);
      end
      data_run  = $urandom_range(8, 40);
      close_run = ($urandom_range(3) != 0);
      for (int k = 0; k < data_run; k++) begin
        send_word(rc4_pkg::MODE_DATA, 8'($urandom_range(255)),
                  (k == data_run - 1) ? close_run : ($urandom_range(63) == 0));
      end
      sess++;
    end
    in_tvalid     <= 1'b0;
    quiet_stretch <= 1'b0;

    while (sb.words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
